@@ sv/tgi_pkg.sv @@
// Shared types, constants and helpers for the trilinear grid interpolator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tgi_pkg;

	localparam int FIRST_AXIS_POINTS  = 16;
	localparam int SECOND_AXIS_POINTS = 16;
	localparam int THIRD_AXIS_POINTS  = 16;
	localparam int MAX_COMPONENTS     = 4;

	localparam int TABLE_DEPTH = FIRST_AXIS_POINTS * SECOND_AXIS_POINTS *
		THIRD_AXIS_POINTS * MAX_COMPONENTS;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	localparam int MAX_POINTS_12 = (FIRST_AXIS_POINTS > SECOND_AXIS_POINTS) ?
		FIRST_AXIS_POINTS : SECOND_AXIS_POINTS;
	localparam int MAX_POINTS = (MAX_POINTS_12 > THIRD_AXIS_POINTS) ?
		MAX_POINTS_12 : THIRD_AXIS_POINTS;
	localparam int CELL_W = $clog2(MAX_POINTS);

	localparam int FRAC_W = 17;
	localparam int COMP_W = 2;
	localparam int COMP_LIMIT = (MAX_COMPONENTS < 4) ? MAX_COMPONENTS : 4;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [FRAC_W-1:0] frac_t;

	localparam frac_t FRAC_ONE = frac_t'(65536);
	localparam cell_t FIRST_LAST_CELL  = cell_t'(FIRST_AXIS_POINTS - 2);
	localparam cell_t SECOND_LAST_CELL = cell_t'(SECOND_AXIS_POINTS - 2);
	localparam cell_t THIRD_LAST_CELL  = cell_t'(THIRD_AXIS_POINTS - 2);

	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [2:0] {
		CFG_FIRST_MIN,
		CFG_FIRST_INV_STEP,
		CFG_SECOND_MIN,
		CFG_SECOND_INV_STEP,
		CFG_THIRD_MIN,
		CFG_THIRD_INV_STEP,
		CFG_COMPONENT_COUNT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOCATE_A,
		ST_LOCATE_B,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic               mode;
		logic [3:0]         write_first_index;
		logic [3:0]         write_second_index;
		logic [3:0]         write_third_index;
		logic [1:0]         write_component;
		logic signed [31:0] write_value;
		logic signed [31:0] query_first;
		logic signed [31:0] query_second;
		logic signed [31:0] query_third;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] blended_value;
		logic [1:0]         component_number;
		logic               last_component;
	} out_word_t;

	function automatic addr_t table_addr(input logic [31:0] i, input logic [31:0] j,
		input logic [31:0] k, input logic [31:0] c);
		logic [31:0] a;
		a = ((i * SECOND_AXIS_POINTS + j) * THIRD_AXIS_POINTS + k) * MAX_COMPONENTS + c;
		return a[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/tgi_sample_ram.sv @@
// Sample table: single write port, single read port, registered read data.
// Depends on tgi_pkg for depth and address type.
`default_nettype none

module tgi_sample_ram (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire tgi_pkg::addr_t     waddr,
	input  wire logic signed [31:0] wdata,
	input  wire tgi_pkg::addr_t     raddr,
	output logic signed [31:0]      rdata
);
	import tgi_pkg::*;

	logic signed [31:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/tgi_locate.sv @@
// One axis: cell index and Q1.16 fraction from a coordinate, two pipeline stages.
// Depends on tgi_pkg for cell and fraction types.
`default_nettype none

module tgi_locate (
	input  wire logic               clk,
	input  wire logic signed [31:0] coord,
	input  wire logic signed [31:0] origin,
	input  wire logic [31:0]        inv_step,
	input  wire tgi_pkg::cell_t     last_cell,
	output tgi_pkg::cell_t          cell_idx,
	output tgi_pkg::frac_t          frac
);
	import tgi_pkg::*;

	logic signed [32:0] diff;
	logic               nonpos;
	logic [63:0]        prod_s1;
	logic               nonpos_s1;
	logic [31:0]        whole;
	cell_t              cell_s2;
	frac_t              frac_s2;

	assign diff   = 33'(coord) - 33'(origin);
	assign nonpos = diff[32] || (diff == 33'sd0);

	always_ff @(posedge clk) begin
		prod_s1   <= 64'(diff[31:0]) * 64'(inv_step);
		nonpos_s1 <= nonpos;
	end

	assign whole = prod_s1[63:32];

	always_ff @(posedge clk) begin
		if (nonpos_s1) begin
			cell_s2 <= '0;
			frac_s2 <= '0;
		end else if (whole > 32'(last_cell)) begin
			cell_s2 <= last_cell;
			frac_s2 <= FRAC_ONE;
		end else begin
			cell_s2 <= whole[CELL_W-1:0];
			frac_s2 <= {1'b0, prod_s1[31:16]};
		end
	end

	assign cell_idx = cell_s2;
	assign frac     = frac_s2;

endmodule

`default_nettype wire

@@ sv/tgi_blend.sv @@
// Linear blend a*(1-f) + b*f with rounding, as a two-stage pipeline.
// Depends on tgi_pkg for the fraction type.
`default_nettype none

module tgi_blend (
	input  wire logic               clk,
	input  wire logic               issue,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	input  wire tgi_pkg::frac_t     f,
	output logic signed [31:0]      y
);
	import tgi_pkg::*;

	logic signed [32:0] diff;
	logic signed [50:0] prod;
	logic signed [50:0] prod_s1;
	logic signed [31:0] a_s1;
	logic signed [51:0] sum;
	logic signed [31:0] y_s2;

	assign diff = 33'(b) - 33'(a);
	assign prod = 51'(diff) * 51'($signed({1'b0, f}));

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1 <= prod;
			a_s1    <= a;
		end
	end

	// a*65536 + (b-a)*f + 0.5, then an arithmetic shift gives the floor.
	assign sum = 52'(prod_s1) + (52'(a_s1) <<< 16) + 52'sd32768;

	always_ff @(posedge clk) begin
		y_s2 <= sum[47:16];
	end

	assign y = y_s2;

endmodule

`default_nettype wire

@@ sv/trilinear_grid_interpolator_core.sv @@
// Trilinear interpolator: a write word goes to the table when accepted in idle; a query
// locates the cell in ST_LOCATE_A and ST_LOCATE_B, then per component makes eight reads
// through the single table read port feeding one two-stage blend unit for seven blends.
// Reset is asynchronous; it restores the register defaults and idles the control,
// while the sample table is not cleared and reads undefined until written.
`default_nettype none

module trilinear_grid_interpolator_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tgi_pkg::in_word_t  in_word,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output tgi_pkg::out_word_t      out_word,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_addr,
	input  wire logic [31:0]        cfg_wdata
);
	import tgi_pkg::*;

	localparam logic [3:0] STEP_EVEN0 = 4'd1;
	localparam logic [3:0] STEP_PAIR0 = 4'd2;
	localparam logic [3:0] STEP_EVEN1 = 4'd3;
	localparam logic [3:0] STEP_PAIR1 = 4'd4;
	localparam logic [3:0] STEP_EVEN2 = 4'd5;
	localparam logic [3:0] STEP_PAIR2 = 4'd6;
	localparam logic [3:0] STEP_EVEN3 = 4'd7;
	localparam logic [3:0] STEP_PAIR3 = 4'd8;
	localparam logic [3:0] STEP_SAVE0 = 4'd9;
	localparam logic [3:0] STEP_MID1  = 4'd10;
	localparam logic [3:0] STEP_FINAL = 4'd12;
	localparam logic [3:0] STEP_DONE  = 4'd14;

	logic signed [31:0] first_min_q, second_min_q, third_min_q;
	logic [31:0]        first_inv_q, second_inv_q, third_inv_q;
	logic [2:0]         count_q;

	state_t             state_q, state_d;
	logic [3:0]         step_q;
	logic [COMP_W-1:0]  comp_q, last_comp_q, last_comp_d;
	logic [2:0]         n_eff;
	logic signed [31:0] qf_q, qs_q, qt_q;

	logic               query_acc, out_load, ram_we;
	addr_t              waddr, raddr;
	logic signed [31:0] rdata;
	cell_t              cell_i, cell_j, cell_k;
	frac_t              frac_i, frac_j, frac_k;

	logic               b_issue;
	logic signed [31:0] b_a, b_b, b_y;
	frac_t              b_f;
	logic signed [31:0] even_q, l1a_q, l1b_q, c0_q;

	logic               out_valid_q;
	out_word_t          out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_min_q  <= '0;
			first_inv_q  <= 32'h0001_0000;
			second_min_q <= '0;
			second_inv_q <= 32'h0001_0000;
			third_min_q  <= '0;
			third_inv_q  <= 32'h0001_0000;
			count_q      <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_FIRST_MIN:       first_min_q  <= cfg_wdata;
				CFG_FIRST_INV_STEP:  first_inv_q  <= cfg_wdata;
				CFG_SECOND_MIN:      second_min_q <= cfg_wdata;
				CFG_SECOND_INV_STEP: second_inv_q <= cfg_wdata;
				CFG_THIRD_MIN:       third_min_q  <= cfg_wdata;
				CFG_THIRD_INV_STEP:  third_inv_q  <= cfg_wdata;
				CFG_COMPONENT_COUNT: count_q      <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (count_q == 3'd0) begin
			n_eff = 3'd1;
		end else if (count_q > 3'(COMP_LIMIT)) begin
			n_eff = 3'(COMP_LIMIT);
		end else begin
			n_eff = count_q;
		end
		last_comp_d = COMP_W'(n_eff - 3'd1);
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && in_word.mode == MODE_QUERY) begin
					state_d = ST_LOCATE_A;
				end
			end
			ST_LOCATE_A: state_d = ST_LOCATE_B;
			ST_LOCATE_B: state_d = ST_RUN;
			ST_RUN: begin
				if (step_q == STEP_DONE && (!out_valid_q || out_ready)) begin
					out_load = 1'b1;
					if (comp_q == last_comp_q) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign query_acc = in_valid && in_ready && in_word.mode == MODE_QUERY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			comp_q      <= '0;
			last_comp_q <= '0;
		end else begin
			state_q <= state_d;
			if (query_acc) begin
				step_q      <= '0;
				comp_q      <= '0;
				last_comp_q <= last_comp_d;
			end else if (out_load) begin
				step_q <= '0;
				comp_q <= comp_q + 1'b1;
			end else if (state_q == ST_RUN && step_q != STEP_DONE) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query_acc) begin
			qf_q <= in_word.query_first;
			qs_q <= in_word.query_second;
			qt_q <= in_word.query_third;
		end
	end

	tgi_locate u_locate_first (
		.clk(clk), .coord(qf_q), .origin(first_min_q), .inv_step(first_inv_q),
		.last_cell(FIRST_LAST_CELL), .cell_idx(cell_i), .frac(frac_i)
	);

	tgi_locate u_locate_second (
		.clk(clk), .coord(qs_q), .origin(second_min_q), .inv_step(second_inv_q),
		.last_cell(SECOND_LAST_CELL), .cell_idx(cell_j), .frac(frac_j)
	);

	tgi_locate u_locate_third (
		.clk(clk), .coord(qt_q), .origin(third_min_q), .inv_step(third_inv_q),
		.last_cell(THIRD_LAST_CELL), .cell_idx(cell_k), .frac(frac_k)
	);

	assign ram_we = in_valid && in_ready && in_word.mode == MODE_WRITE &&
		32'(in_word.write_first_index) < 32'(FIRST_AXIS_POINTS) &&
		32'(in_word.write_second_index) < 32'(SECOND_AXIS_POINTS) &&
		32'(in_word.write_third_index) < 32'(THIRD_AXIS_POINTS) &&
		32'(in_word.write_component) < 32'(MAX_COMPONENTS);

	assign waddr = table_addr(32'(in_word.write_first_index),
		32'(in_word.write_second_index), 32'(in_word.write_third_index),
		32'(in_word.write_component));

	// Corner order follows the step bits: first axis fastest, third axis slowest.
	assign raddr = table_addr(32'(cell_i) + 32'(step_q[0]), 32'(cell_j) + 32'(step_q[1]),
		32'(cell_k) + 32'(step_q[2]), 32'(comp_q));

	tgi_sample_ram u_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(in_word.write_value),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		b_issue = 1'b0;
		b_a     = even_q;
		b_b     = rdata;
		b_f     = frac_i;
		case (step_q)
			STEP_PAIR0, STEP_PAIR1, STEP_PAIR2, STEP_PAIR3: begin
				b_issue = (state_q == ST_RUN);
			end
			STEP_EVEN3: begin
				b_issue = (state_q == ST_RUN);
				b_a     = l1a_q;
				b_b     = l1b_q;
				b_f     = frac_j;
			end
			STEP_MID1: begin
				b_issue = (state_q == ST_RUN);
				b_a     = l1a_q;
				b_b     = b_y;
				b_f     = frac_j;
			end
			STEP_FINAL: begin
				b_issue = (state_q == ST_RUN);
				b_a     = c0_q;
				b_b     = b_y;
				b_f     = frac_k;
			end
			default: ;
		endcase
	end

	tgi_blend u_blend (
		.clk(clk), .issue(b_issue), .a(b_a), .b(b_b), .f(b_f), .y(b_y)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			case (step_q)
				STEP_EVEN0, STEP_EVEN1, STEP_EVEN2, STEP_EVEN3: even_q <= rdata;
				STEP_PAIR1, STEP_PAIR3: l1a_q <= b_y;
				STEP_PAIR2: l1b_q <= b_y;
				STEP_SAVE0: c0_q <= b_y;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.blended_value    <= b_y;
			out_q.component_number <= comp_q;
			out_q.last_component   <= (comp_q == last_comp_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_query_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !in_ready)
		else $error("input taken while a query is being located");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= STEP_DONE)
		else $error("component step counter ran past its last step");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && comp_q == last_comp_q) |=> in_ready)
		else $error("block did not return to idle after the last component");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for trilinear_grid_interpolator_core: table loads and queries
// are predicted and checked word by word under random stalls and several register settings.
// Depends on tgi_pkg and the core module only.
`timescale 1ns / 100ps

module testbench;
	import tgi_pkg::*;

	class interp_scoreboard;
		logic signed [31:0] axis_min [3] = '{32'sd0, 32'sd0, 32'sd0};
		logic [31:0]        inv_step [3] = '{32'h10000, 32'h10000, 32'h10000};
		int                 axis_points [3] = '{FIRST_AXIS_POINTS, SECOND_AXIS_POINTS,
			THIRD_AXIS_POINTS};
		logic [2:0]         comp_count = 3'd1;
		logic signed [31:0] samples [int];
		out_word_t          pending [$];
		int                 errors = 0;
		int                 writes = 0;
		int                 queries = 0;
		int                 checked = 0;

		function void set_reg(cfg_reg_t r, logic [31:0] v);
			case (r)
				CFG_FIRST_MIN:       axis_min[0] = v;
				CFG_FIRST_INV_STEP:  inv_step[0] = v;
				CFG_SECOND_MIN:      axis_min[1] = v;
				CFG_SECOND_INV_STEP: inv_step[1] = v;
				CFG_THIRD_MIN:       axis_min[2] = v;
				CFG_THIRD_INV_STEP:  inv_step[2] = v;
				CFG_COMPONENT_COUNT: comp_count = v[2:0];
				default: ;
			endcase
		endfunction

		function int comp_total();
			int n;
			n = comp_count;
			if (n == 0) n = 1;
			if (n > MAX_COMPONENTS) n = MAX_COMPONENTS;
			if (n > 4) n = 4;
			return n;
		endfunction

		function int entry(int i, int j, int k, int c);
			return ((i * SECOND_AXIS_POINTS + j) * THIRD_AXIS_POINTS + k) * MAX_COMPONENTS + c;
		endfunction

		function logic signed [31:0] sample(int i, int j, int k, int c);
			int a;
			a = entry(i, j, k, c);
			return samples.exists(a) ? samples[a] : 32'sd0;
		endfunction

		// Cell index and a 0..65536 fraction along one axis.
		function void locate(int axis, logic signed [31:0] q, output int idx, output int frac);
			longint      d;
			logic [63:0] span;
			logic [63:0] prod;
			d = longint'(q) - longint'(axis_min[axis]);
			if (d <= 0) begin
				idx = 0;
				frac = 0;
				return;
			end
			span = d;
			prod = span * {32'd0, inv_step[axis]};
			if (prod[63:32] > axis_points[axis] - 2) begin
				idx = axis_points[axis] - 2;
				frac = 65536;
			end else begin
				idx = prod[63:32];
				frac = prod[31:16];
			end
		endfunction

		function logic signed [31:0] mix(logic signed [31:0] a, logic signed [31:0] b, int f);
			logic signed [63:0] s;
			s = longint'(a) * longint'(65536 - f) + longint'(b) * longint'(f) + 64'sd32768;
			return s[47:16];
		endfunction

		function void note_input(in_word_t w);
			int                 i, j, k, fi, fj, fk, n;
			logic signed [31:0] c00, c01, c10, c11, c0, c1;
			out_word_t          r;
			if (w.mode == MODE_WRITE) begin
				writes++;
				if (w.write_first_index < FIRST_AXIS_POINTS &&
					w.write_second_index < SECOND_AXIS_POINTS &&
					w.write_third_index < THIRD_AXIS_POINTS &&
					w.write_component < MAX_COMPONENTS)
					samples[entry(w.write_first_index, w.write_second_index,
						w.write_third_index, w.write_component)] = w.write_value;
				return;
			end
			queries++;
			locate(0, w.query_first, i, fi);
			locate(1, w.query_second, j, fj);
			locate(2, w.query_third, k, fk);
			n = comp_total();
			for (int c = 0; c < n; c++) begin
				c00 = mix(sample(i, j, k, c), sample(i + 1, j, k, c), fi);
				c01 = mix(sample(i, j + 1, k, c), sample(i + 1, j + 1, k, c), fi);
				c10 = mix(sample(i, j, k + 1, c), sample(i + 1, j, k + 1, c), fi);
				c11 = mix(sample(i, j + 1, k + 1, c), sample(i + 1, j + 1, k + 1, c), fi);
				c0 = mix(c00, c01, fj);
				c1 = mix(c10, c11, fj);
				r.blended_value = mix(c0, c1, fk);
				r.component_number = 2'(c);
				r.last_component = (c == n - 1);
				pending = {pending, r};
			end
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.blended_value !== exp.blended_value) begin
				$display("%0t: blended_value expected %h got %h", $time,
					exp.blended_value, got.blended_value);
				errors++;
			end
			if (got.component_number !== exp.component_number) begin
				$display("%0t: component_number expected %0d got %0d", $time,
					exp.component_number, got.component_number);
				errors++;
			end
			if (got.last_component !== exp.last_component) begin
				$display("%0t: last_component expected %0d got %0d", $time,
					exp.last_component, got.last_component);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_word_t    in_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_word_t   out_word;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	interp_scoreboard sb = new();
	bit filled [TABLE_DEPTH];
	bit steady = 1'b0;
	int sent_items = 0;
	int settings_used = 1;

	trilinear_grid_interpolator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.note_input(in_word);
			if (out_valid && out_ready) sb.check_result(out_word);
		end
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly coordinates that land inside the grid, some raw and some at the edges.
	function automatic logic signed [31:0] pick_coord(int axis);
		longint      c;
		logic [63:0] t;
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return sb.axis_min[axis];
					default: return sb.axis_min[axis] + 32'sd1;
				endcase
			end
			default: begin
				if (sb.inv_step[axis] == 0) return $urandom;
				t = $urandom_range(0, 16 * 65536 - 1);
				c = longint'(sb.axis_min[axis]) +
					longint'((t << 16) / {32'd0, sb.inv_step[axis]});
				if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
				return c[31:0];
			end
		endcase
	endfunction

	task automatic send_word(in_word_t w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		sent_items++;
	endtask

	task automatic send_write(int i, int j, int k, int c, logic signed [31:0] v);
		logic [159:0] junk;
		in_word_t     w;
		junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = junk[$bits(in_word_t)-1:0];
		w.mode = MODE_WRITE;
		w.write_first_index = 4'(i);
		w.write_second_index = 4'(j);
		w.write_third_index = 4'(k);
		w.write_component = 2'(c);
		w.write_value = v;
		filled[sb.entry(i, j, k, c)] = 1'b1;
		send_word(w);
	endtask

	// Loads any corner of the target cell that was never written, then queries it.
	task automatic send_query(logic signed [31:0] qa, logic signed [31:0] qb,
		logic signed [31:0] qc);
		int           ci, cj, ck, f, n;
		logic [159:0] junk;
		in_word_t     w;
		sb.locate(0, qa, ci, f);
		sb.locate(1, qb, cj, f);
		sb.locate(2, qc, ck, f);
		n = sb.comp_total();
		for (int d = 0; d < 8; d++) begin
			for (int c = 0; c < n; c++) begin
				if (!filled[sb.entry(ci + d[0], cj + d[1], ck + d[2], c)])
					send_write(ci + d[0], cj + d[1], ck + d[2], c, pick_sample());
			end
		end
		junk = {$urandom, $urandom, $urandom, $urandom, $urandom};
		w = junk[$bits(in_word_t)-1:0];
		w.mode = MODE_QUERY;
		w.query_first = qa;
		w.query_second = qb;
		w.query_third = qc;
		send_word(w);
	endtask

	// Drops in_valid and waits at an edge first, so the monitor has noted the word accepted at the last edge.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic load_setting(int p);
		logic [31:0] regs [7];
		case (p)
			1: regs = '{32'h0, 32'h10000, 32'h0, 32'h10000, 32'h0, 32'h10000, 32'd4};
			2: begin
				for (int a = 0; a < 3; a++) begin
					regs[2 * a] = $urandom_range(0, 32'h10_0000) - 32'h8_0000;
					regs[2 * a + 1] = $urandom_range(32'h4000, 32'h4_0000);
				end
				regs[6] = $urandom_range(1, 4);
			end
			3: regs = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
				32'h8000_0000, 32'hFFFF_FFFF, 32'd7};
			4: regs = '{32'h7FFF_FFFF, 32'h10000, 32'h0, 32'h0, 32'h8000_0000, 32'h1, 32'd0};
			5: begin
				for (int a = 0; a < 6; a++) regs[a] = $urandom;
				regs[6] = $urandom_range(0, 7);
			end
			default: regs = '{32'h10000, 32'h20000, 32'hFFFF_8000, 32'h8000, 32'h0,
				32'h10000, 32'd3};
		endcase
		for (int r = CFG_FIRST_MIN; r <= CFG_COMPONENT_COUNT; r++) begin
			cfg_we <= 1'b1;
			cfg_addr <= cfg_reg_t'(r);
			cfg_wdata <= regs[r];
			sb.set_reg(cfg_reg_t'(r), regs[r]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic run_random(int count);
		int stop;
		stop = sent_items + count;
		while (sent_items < stop) begin
			steady = ((sent_items / 30) % 4) == 1;
			if ($urandom_range(0, 9) < 2)
				send_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 3), pick_sample());
			else
				send_query(pick_coord(0), pick_coord(1), pick_coord(2));
		end
	endtask

	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			gap = (taken == 60) ? 400 : draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opposite extremes on alternating corners of the origin cell.
		for (int d = 0; d < 8; d++)
			send_write(d[0], d[1], d[2], 0,
				(d[0] ^ d[1] ^ d[2]) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
		send_query(32'sh0, 32'sh0, 32'sh0);
		send_query(32'sh8000, 32'sh8000, 32'sh8000);
		send_query(32'shFFFF_0000, 32'sh8000_0000, 32'sh0000_FFFF);
		send_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_query(32'sh000F_0000, 32'sh000E_8000, 32'sh000E_FFFF);

		for (int p = 1; p <= 6; p++) begin
			wait_idle();
			load_setting(p);
			run_random(73);
		end
		wait_idle();

		$display("Covered %0d table writes and %0d queries under %0d register settings.",
			sb.writes, sb.queries, settings_used);
		$display("Checked %0d result words; %0d field errors.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d result words outstanding.", sb.pending.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
sv/tgi_pkg.sv
sv/tgi_sample_ram.sv
sv/tgi_locate.sv
sv/tgi_blend.sv
sv/trilinear_grid_interpolator_core.sv
test/testbench.sv
